// ===== rtl/heat_diffusion_stencil_step_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heat diffusion stencil block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_STEP_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hds_pkg.sv =====
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants
// Register indexes, fixed field widths and the per-word classification flags.
// ----------------------------------------------------------------------------
package hds_pkg;

  // Fixed widths of the configuration fields.
  localparam int CFG_SIZE_W = 11;
  localparam int COEF_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Largest grid size a size register can hold.
  localparam int CFG_SIZE_MAX = (1 << CFG_SIZE_W) - 1;

  // Grid size limits and reset values.
  localparam int GRID_MIN   = 3;
  localparam int GRID_RESET = 1024;

  // Coefficients are unsigned Q0.16.
  localparam int FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_COEF_X    = 2'd2,
    REG_COEF_Y    = 2'd3
  } hds_reg_e;

  // Classification of one arriving cell.
  typedef struct packed {
    logic has_prev;   // a result for the row above is due
    logic interior;   // that result is a stencil update, not a pass-through
    logic emit_last;  // the cell itself lies on the last row and is emitted
    logic frame_end;  // the cell is the final cell of the grid
  } hds_flags_t;

endpackage

// ===== rtl/hds_front.sv =====
// ----------------------------------------------------------------------------
// hds_front: position tracking and classification
// Accepts cells, keeps the raster position and tags each word for the back end.
// ----------------------------------------------------------------------------
module hds_front import hds_pkg::*; #(
  parameter int ROW_W = 10,
  parameter int COL_W = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  q_full_i,
  input  logic [CFG_SIZE_W-1:0] rows_i,
  input  logic [CFG_SIZE_W-1:0] cols_i,
  output logic                  push_o,
  output logic [ROW_W-1:0]      row_o,
  output logic [COL_W-1:0]      col_o,
  output hds_flags_t            flags_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             wrap_c;
  logic [ROW_W:0]   row_pre;
  logic [ROW_W-1:0] cur_r;
  logic [COL_W-1:0] cur_c;
  logic             last_r, last_c;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // A size change between frames can leave the stored position outside the
  // grid; it wraps before the cell is placed.
  always_comb begin
    wrap_c  = int'(col_q) >= int'(cols_i);
    row_pre = wrap_c ? ({1'b0, row_q} + (ROW_W+1)'(1)) : {1'b0, row_q};
    cur_r   = (int'(row_pre) >= int'(rows_i)) ? '0 : row_pre[ROW_W-1:0];
    cur_c   = wrap_c ? '0 : col_q;
    last_r  = int'(cur_r) == int'(rows_i) - 1;
    last_c  = int'(cur_c) == int'(cols_i) - 1;
  end

  always_comb begin
    flags_o.has_prev  = cur_r != '0;
    flags_o.interior  = (cur_r != '0) && (cur_r != ROW_W'(1)) &&
                        (cur_c != '0) && !last_c;
    flags_o.emit_last = last_r;
    flags_o.frame_end = last_r && last_c;
  end

  assign row_o = cur_r;
  assign col_o = cur_c;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (last_c) begin
        col_d = '0;
        row_d = last_r ? '0 : cur_r + ROW_W'(1);
      end else begin
        col_d = cur_c + COL_W'(1);
        row_d = cur_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/hds_fifo.sv =====
// ----------------------------------------------------------------------------
// hds_fifo: two-entry queue
// Show-ahead queue that lets the front and the back end stall independently.
// ----------------------------------------------------------------------------
module hds_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/hds_back.sv =====
// ----------------------------------------------------------------------------
// hds_back: line stores, stencil arithmetic and result register
// Reads the neighbours, forms both weighted second differences, saturates,
// and hands out up to two result words per cell.
// ----------------------------------------------------------------------------
module hds_back import hds_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_COLS   = 1024,
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  logic signed [VALUE_BITS-1:0] q_cell_i,
  input  logic [ROW_W-1:0]             q_row_i,
  input  logic [COL_W-1:0]             q_col_i,
  input  hds_flags_t                   q_flags_i,
  output logic                         q_pop_o,
  input  logic [COEF_W-1:0]            coef_x_i,
  input  logic [COEF_W-1:0]            coef_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ROW_W-1:0]             out_row_o,
  output logic [COL_W-1:0]             out_col_o,
  output logic signed [VALUE_BITS-1:0] cell_out_o,
  output logic                         frame_end_o
);

  localparam int DIFF_W = VALUE_BITS + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;

  logic [VALUE_BITS-1:0] older_mem  [MAX_COLS];
  logic [VALUE_BITS-1:0] recent_mem [MAX_COLS];

  logic en;

  // Stage 1: line store reads.
  logic                  v1_q;
  logic [VALUE_BITS-1:0] cell1_q, u1_q, up1_q, rt1_q, prev_u_q;
  logic [ROW_W-1:0]      row1_q;
  logic [COL_W-1:0]      col1_q;
  hds_flags_t            flags1_q;
  logic [COL_W-1:0]      rt_addr;

  // Stage 1 arithmetic.
  logic signed [DIFF_W-1:0] up_x, dn_x, lf_x, rt_x, twice_u, dv, dh;
  logic signed [PROD_W-1:0] prod_v, prod_h;

  // Stage 2: weighted terms.
  logic                     v2_q;
  logic [VALUE_BITS-1:0]    u2_q, cell2_q;
  logic signed [TERM_W-1:0] tv2_q, th2_q;
  logic [ROW_W-1:0]         row2_q;
  logic [COL_W-1:0]         col2_q;
  hds_flags_t               flags2_q;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-VALUE_BITS:0] sum_top;
  logic [VALUE_BITS-1:0]    sat;

  // Result register: word A is the row above, word B the last-row cell.
  logic                  a_q, b_q, fe_q;
  logic [VALUE_BITS-1:0] res_a_q, cell_b_q;
  logic [ROW_W-1:0]      row3_q;
  logic [COL_W-1:0]      col3_q;

  // The whole pipeline moves when the result register is free or gives
  // out its last pending word in this cycle.
  assign en      = !(a_q || b_q) || (out_ready_i && (a_q != b_q));
  assign q_pop_o = q_valid_i && en;

  assign rt_addr = (int'(q_col_i) == MAX_COLS - 1) ? '0 : q_col_i + COL_W'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cell1_q  <= q_cell_i;
      row1_q   <= q_row_i;
      col1_q   <= q_col_i;
      flags1_q <= q_flags_i;
      u1_q     <= recent_mem[q_col_i];
      up1_q    <= older_mem[q_col_i];
      rt1_q    <= recent_mem[rt_addr];
    end
    // Writes lag the reads by one word; a word never reads the column that
    // the word ahead of it writes.
    if (en && v1_q) begin
      older_mem[col1_q]  <= u1_q;
      recent_mem[col1_q] <= cell1_q;
      prev_u_q           <= u1_q;
    end
  end

  // The left neighbour is the centre of the word before, same row.
  always_comb begin
    up_x    = {{2{up1_q[VALUE_BITS-1]}}, up1_q};
    dn_x    = {{2{cell1_q[VALUE_BITS-1]}}, cell1_q};
    lf_x    = {{2{prev_u_q[VALUE_BITS-1]}}, prev_u_q};
    rt_x    = {{2{rt1_q[VALUE_BITS-1]}}, rt1_q};
    twice_u = {u1_q[VALUE_BITS-1], u1_q, 1'b0};
    dv      = up_x - twice_u + dn_x;
    dh      = lf_x - twice_u + rt_x;
    prod_v  = PROD_W'(dv) * PROD_W'($signed({1'b0, coef_x_i}));
    prod_h  = PROD_W'(dh) * PROD_W'($signed({1'b0, coef_y_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u2_q     <= u1_q;
      cell2_q  <= cell1_q;
      row2_q   <= row1_q;
      col2_q   <= col1_q;
      flags2_q <= flags1_q;
      // Dropping the fraction bits of a signed product floors it.
      tv2_q    <= prod_v[PROD_W-1:FRAC_BITS];
      th2_q    <= prod_h[PROD_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    sum = {{(SUM_W-VALUE_BITS){u2_q[VALUE_BITS-1]}}, u2_q}
        + {{2{tv2_q[TERM_W-1]}}, tv2_q}
        + {{2{th2_q[TERM_W-1]}}, th2_q};
    sum_top = sum[SUM_W-1:VALUE_BITS-1];
    if (sum_top == '0 || sum_top == '1) begin
      sat = sum[VALUE_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_a_q  <= flags2_q.interior ? sat : u2_q;
      cell_b_q <= cell2_q;
      row3_q   <= row2_q;
      col3_q   <= col2_q;
      fe_q     <= flags2_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      a_q  <= 1'b0;
      b_q  <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      a_q  <= v2_q && flags2_q.has_prev;
      b_q  <= v2_q && flags2_q.emit_last;
    end else if (out_ready_i) begin
      // Both words pending: word A leaves first.
      a_q <= 1'b0;
    end
  end

  assign out_valid_o = a_q || b_q;
  assign out_row_o   = a_q ? row3_q - ROW_W'(1) : row3_q;
  assign out_col_o   = col3_q;
  assign cell_out_o  = a_q ? res_a_q : cell_b_q;
  assign frame_end_o = b_q && !a_q && fe_q;

endmodule

// ===== rtl/heat_diffusion_stencil_step.sv =====
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step: five-point explicit heat-equation stencil
// Cells enter on the in channel (in_valid_i/in_ready_o, cell_in_i) in raster
// order, one word per clock while in_ready_o is high. When cell (r,c) arrives,
// the word for (r-1,c) comes out on the out channel with its row, column and
// new temperature; on the last row the arriving cell follows it unchanged, and
// frame_end_o marks the final cell. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Throughput is one word per
// clock while out_ready_i is high; on the last row two result words leave per
// input word and the result register takes a new word once both have left.
// First result path: queue, line store read, multiply, then saturating sum.
// Reset clears the position to row 0, column 0 and the registers to their
// defaults; the line stores are not cleared and are valid once the first
// rows of a frame have passed. A stalled receiver holds the result register;
// the two-word queue fills and in_ready_o then drops.
// ----------------------------------------------------------------------------
`include "heat_diffusion_stencil_step_defines.svh"

module heat_diffusion_stencil_step import hds_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] cell_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [$clog2(MAX_ROWS)-1:0]  out_row_o,
  output logic [$clog2(MAX_COLS)-1:0]  out_col_o,
  output logic signed [VALUE_BITS-1:0] cell_out_o,
  output logic                         frame_end_o
);

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROWS_LIM = (MAX_ROWS < CFG_SIZE_MAX) ? MAX_ROWS : CFG_SIZE_MAX;
  localparam int COLS_LIM = (MAX_COLS < CFG_SIZE_MAX) ? MAX_COLS : CFG_SIZE_MAX;
  localparam int FLAG_W   = $bits(hds_flags_t);
  localparam int Q_W      = VALUE_BITS + ROW_W + COL_W + FLAG_W;

  // Configuration registers.
  logic [CFG_SIZE_W-1:0] grid_rows_q, grid_cols_q;
  logic [COEF_W-1:0]     coef_x_q, coef_y_q;
  logic [CFG_SIZE_W-1:0] rows_eff, cols_eff;
  hds_reg_e              cfg_reg;

  assign cfg_reg = hds_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_SIZE_W'(GRID_RESET);
      grid_cols_q <= CFG_SIZE_W'(GRID_RESET);
      coef_x_q    <= '0;
      coef_y_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_GRID_COLS: grid_cols_q <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_COEF_X:    coef_x_q    <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Y:    coef_y_q    <= cfg_data_i[COEF_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sizes outside the supported range are clamped where they are used.
  always_comb begin
    if (int'(grid_rows_q) < GRID_MIN) begin
      rows_eff = CFG_SIZE_W'(GRID_MIN);
    end else if (int'(grid_rows_q) > ROWS_LIM) begin
      rows_eff = CFG_SIZE_W'(ROWS_LIM);
    end else begin
      rows_eff = grid_rows_q;
    end
    if (int'(grid_cols_q) < GRID_MIN) begin
      cols_eff = CFG_SIZE_W'(GRID_MIN);
    end else if (int'(grid_cols_q) > COLS_LIM) begin
      cols_eff = CFG_SIZE_W'(COLS_LIM);
    end else begin
      cols_eff = grid_cols_q;
    end
  end

  // Front end: position and classification of each arriving word.
  logic             push, q_full;
  logic [ROW_W-1:0] f_row;
  logic [COL_W-1:0] f_col;
  hds_flags_t       f_flags;

  hds_front #(
    .ROW_W(ROW_W),
    .COL_W(COL_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .rows_i     (rows_eff),
    .cols_i     (cols_eff),
    .push_o     (push),
    .row_o      (f_row),
    .col_o      (f_col),
    .flags_o    (f_flags)
  );

  // Queue between the front and the back end.
  logic [Q_W-1:0]              q_wdata, q_rdata;
  logic                        q_valid, q_pop;
  logic signed [VALUE_BITS-1:0] q_cell;
  logic [ROW_W-1:0]            q_row;
  logic [COL_W-1:0]            q_col;
  hds_flags_t                  q_flags;

  assign q_wdata = {f_flags, f_row, f_col, cell_in_i};
  assign {q_flags, q_row, q_col, q_cell} = q_rdata;

  hds_fifo #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .valid_o (q_valid)
  );

  // Back end: line stores, arithmetic and result register.
  hds_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_COLS  (MAX_COLS),
    .ROW_W     (ROW_W),
    .COL_W     (COL_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cell_i    (q_cell),
    .q_row_i     (q_row),
    .q_col_i     (q_col),
    .q_flags_i   (q_flags),
    .q_pop_o     (q_pop),
    .coef_x_i    (coef_x_q),
    .coef_y_i    (coef_y_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .cell_out_o  (cell_out_o),
    .frame_end_o (frame_end_o)
  );

  // An accepted input word is waiting in the queue in the next cycle.
  `HDS_ASSERT_NEXT(a_push_lands, in_valid_i && in_ready_o, q_valid, "accepted word lost before queue")
  // A stalled result register freezes the back end.
  `HDS_ASSERT_NOW(a_stall_no_pop, out_valid_o && !out_ready_i, !q_pop, "queue popped under stall")
  // The frame end marker only comes with the last column of the grid.
  `HDS_ASSERT_NOW(a_frame_end_col, out_valid_o && frame_end_o, int'(out_col_o) == int'(cols_eff) - 1, "frame end off the last column")
  // Emitted rows lie inside the grid.
  `HDS_ASSERT_NOW(a_row_in_grid, out_valid_o, int'(out_row_o) < int'(rows_eff), "result row outside grid")

endmodule
